// ===== sv/tccw_pkg.sv =====
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 2 * BYTE_W;

  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;

  localparam logic [BYTE_W-1:0] BLANK_COLOR_RST = 8'd15;

  typedef enum logic [1:0] {
    CMD_PUT        = 2'd0,
    CMD_SET_CURSOR = 2'd1,
    CMD_CLEAR      = 2'd2,
    CMD_READ       = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SWEEP  = 5'b00010,
    S_SCROLL = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_READ   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] color;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } req_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
    logic [BYTE_W-1:0] cell_char;
    logic [BYTE_W-1:0] cell_color;
  } rsp_t;

endpackage

// ===== sv/tccw_cell_ram.sv =====
`timescale 1ns / 1ps

module tccw_cell_ram
  import tccw_pkg::*;
#(
  parameter int DEPTH = ROWS_DEF * COLS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/text_console_cell_writer_top.sv =====
`timescale 1ns / 1ps

// Text console cell writer: a ROWS x COLS store of {color, char} cells and a cursor.
// Command channel: req is taken at a clock edge with start high and busy low.
// Each command gives one result word on rsp, valid for the single cycle that done
// is high; the receiver cannot stall it, so it must take rsp whenever done is up.
// Path from the accepting edge to done:
//   put char (no scroll), newline, return, backspace, set cursor: done is set at the
//     accepting edge and busy stays low, so a new command can follow every cycle.
//   read cell: the registered read of the cell memory, then the S_READ state.
//   clear screen: the S_SWEEP state, one cell written per cycle.
//   put char or newline that scrolls: S_SCROLL, then S_DRAIN; the copy streams
//     through the memory's read and write ports one cell per cycle.
// Config channel (cfg_valid/cfg_ready/cfg_data) sets the blank color; cfg_ready
// is always high. Write it only while the block is idle.
// Reset (rst, synchronous): cursor homes, blank color returns to 15 and the store
// is swept to blank spaces with busy high.
module text_console_cell_writer_top
  import tccw_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              req,
  output logic              done,
  output rsp_t              rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BYTE_W-1:0] cfg_data
);

  localparam int NCELLS = ROWS * COLS;
  localparam int AW     = $clog2(NCELLS);

  state_t            state;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [AW-1:0]     cur_addr;
  logic [BYTE_W-1:0] blank_color;
  logic [AW-1:0]     cnt;
  logic [BYTE_W-1:0] sweep_color;
  logic              sweep_report;
  logic              wv;
  logic [AW-1:0]     waddr_d;
  logic              wblank;

  logic              accept;
  logic [ROW_W-1:0]  sat_row;
  logic [COL_W-1:0]  sat_col;
  logic [AW-1:0]     tgt_addr;
  logic              is_nl;
  logic              is_cr;
  logic              is_bs;
  logic              last_row;
  logic              last_col;
  logic [ROW_W-1:0]  nxt_row;
  logic [COL_W-1:0]  nxt_col;
  logic [AW-1:0]     nxt_addr;
  logic              need_scroll;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  assign busy      = (state != S_IDLE);
  assign accept    = start && (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign sat_row  = (32'(req.row) >= ROWS) ? ROW_W'(ROWS - 1) : req.row;
  assign sat_col  = (32'(req.col) >= COLS) ? COL_W'(COLS - 1) : req.col;
  assign tgt_addr = AW'(sat_row) * AW'(COLS) + AW'(sat_col);

  assign is_nl    = (req.char_code == CH_NEWLINE);
  assign is_cr    = (req.char_code == CH_RETURN);
  assign is_bs    = (req.char_code == CH_BACKSPACE);
  assign last_row = (cur_row == ROW_W'(ROWS - 1));
  assign last_col = (cur_col == COL_W'(COLS - 1));

  // cursor after a put-char command, kept as row, column and linear address
  always_comb begin
    nxt_row     = cur_row;
    nxt_col     = cur_col;
    nxt_addr    = cur_addr;
    need_scroll = 1'b0;
    priority if (is_nl) begin
      if (last_row) begin
        need_scroll = 1'b1;
      end else begin
        nxt_row  = cur_row + 1'b1;
        nxt_col  = '0;
        nxt_addr = cur_addr + AW'(COLS) - AW'(cur_col);
      end
    end else if (is_cr) begin
      nxt_col  = '0;
      nxt_addr = cur_addr - AW'(cur_col);
    end else if (is_bs) begin
      if (cur_col != '0) begin
        nxt_col  = cur_col - 1'b1;
        nxt_addr = cur_addr - 1'b1;
      end else if (cur_row != '0) begin
        nxt_row  = cur_row - 1'b1;
        nxt_col  = COL_W'(COLS - 1);
        nxt_addr = cur_addr - 1'b1;
      end
    end else begin
      if (!last_col) begin
        nxt_col  = cur_col + 1'b1;
        nxt_addr = cur_addr + 1'b1;
      end else if (!last_row) begin
        nxt_row  = cur_row + 1'b1;
        nxt_col  = '0;
        nxt_addr = cur_addr + 1'b1;
      end else begin
        need_scroll = 1'b1;
      end
    end
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = {req.color, req.char_code};
    mem_raddr = tgt_addr;
    unique case (state)
      S_IDLE: begin
        if (accept && (cmd_e'(req.cmd) == CMD_PUT) && !is_nl && !is_cr) begin
          mem_we = 1'b1;
          if (is_bs) begin
            mem_waddr = nxt_addr;
            mem_wdata = {req.color, CH_SPACE};
          end
        end
      end
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = {sweep_color, CH_SPACE};
      end
      S_SCROLL, S_DRAIN: begin
        // read one row ahead, write the word back in the following cycle
        mem_we    = wv;
        mem_waddr = waddr_d;
        mem_wdata = wblank ? {blank_color, CH_SPACE} : mem_rdata;
        mem_raddr = cnt + AW'(COLS);
      end
      S_READ: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  tccw_cell_ram #(
    .DEPTH(NCELLS),
    .AW   (AW)
  ) u_cell_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      cnt          <= '0;
      sweep_color  <= BLANK_COLOR_RST;
      sweep_report <= 1'b0;
      cur_row      <= '0;
      cur_col      <= '0;
      cur_addr     <= '0;
      blank_color  <= BLANK_COLOR_RST;
      done         <= 1'b0;
      wv           <= 1'b0;
    end else begin
      done <= 1'b0;
      wv   <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        blank_color <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rsp.scrolled   <= 1'b0;
            rsp.cell_char  <= '0;
            rsp.cell_color <= '0;
            unique case (cmd_e'(req.cmd))
              CMD_PUT: begin
                if (need_scroll) begin
                  state    <= S_SCROLL;
                  cnt      <= '0;
                  cur_row  <= ROW_W'(ROWS - 1);
                  cur_col  <= '0;
                  cur_addr <= AW'(NCELLS - COLS);
                end else begin
                  done            <= 1'b1;
                  cur_row         <= nxt_row;
                  cur_col         <= nxt_col;
                  cur_addr        <= nxt_addr;
                  rsp.cursor_row  <= nxt_row;
                  rsp.cursor_col  <= nxt_col;
                end
              end
              CMD_SET_CURSOR: begin
                done           <= 1'b1;
                cur_row        <= sat_row;
                cur_col        <= sat_col;
                cur_addr       <= tgt_addr;
                rsp.cursor_row <= sat_row;
                rsp.cursor_col <= sat_col;
              end
              CMD_CLEAR: begin
                state        <= S_SWEEP;
                cnt          <= '0;
                sweep_color  <= blank_color;
                sweep_report <= 1'b1;
                cur_row      <= '0;
                cur_col      <= '0;
                cur_addr     <= '0;
              end
              CMD_READ: begin
                state <= S_READ;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == AW'(NCELLS - 1)) begin
            state          <= S_IDLE;
            done           <= sweep_report;
            rsp.cursor_row <= cur_row;
            rsp.cursor_col <= cur_col;
            rsp.scrolled   <= 1'b0;
            rsp.cell_char  <= '0;
            rsp.cell_color <= '0;
          end
        end
        S_SCROLL: begin
          wv      <= 1'b1;
          waddr_d <= cnt;
          wblank  <= (cnt >= AW'(NCELLS - COLS));
          cnt     <= cnt + 1'b1;
          if (cnt == AW'(NCELLS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state          <= S_IDLE;
          done           <= 1'b1;
          rsp.cursor_row <= cur_row;
          rsp.cursor_col <= cur_col;
          rsp.scrolled   <= 1'b1;
          rsp.cell_char  <= '0;
          rsp.cell_color <= '0;
        end
        S_READ: begin
          state          <= S_IDLE;
          done           <= 1'b1;
          rsp.cursor_row <= cur_row;
          rsp.cursor_col <= cur_col;
          rsp.scrolled   <= 1'b0;
          rsp.cell_char  <= mem_rdata[BYTE_W-1:0];
          rsp.cell_color <= mem_rdata[CELL_W-1:BYTE_W];
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe outside idle state");

  a_addr_track: assert property (@(posedge clk) disable iff (rst)
    cur_addr == AW'(cur_row) * AW'(COLS) + AW'(cur_col))
    else $error("linear cursor address out of step with row and column");

  a_scroll_home: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.scrolled) |->
      (rsp.cursor_row == ROW_W'(ROWS - 1)) && (rsp.cursor_col == '0))
    else $error("scroll did not leave cursor at bottom row start");

  a_read_next: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd_e'(req.cmd) == CMD_READ)) |=> (state == S_READ))
    else $error("read cell did not enter read state");
`endif

endmodule
